/* hdl/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and helpers for the bitmap section allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int SECTION_COUNT_DEF = 64;
  localparam int SECTION_SHIFT_DEF = 20;
  localparam int ADDR_W            = 32;
  localparam int ROW_BITS          = 64;
  localparam int COL_W             = 6;
  localparam int STATUS_W          = 2;
  localparam int CFG_ADDR_W        = 3;
  localparam int M_TDATA_W         = 40;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_GRANTED = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_FREED   = 2'd2,
    STATUS_RANGE   = 2'd3
  } status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } state_t;

  localparam logic [CFG_ADDR_W-1:0] REG_REGION_BASE = 3'd0;

  // lowest clear bit of a row; only meaningful when the row is not all ones
  function automatic logic [COL_W-1:0] first_zero(input logic [ROW_BITS-1:0] row);
    logic [COL_W-1:0] col;
    col = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!row[i]) begin
        col = COL_W'(i);
      end
    end
    return col;
  endfunction

endpackage

/* hdl/bitmap_section_allocator_core.sv */
// ----------------------------------------------------------------------------
// bitmap_section_allocator_core
// First-free allocator over a bitmap of fixed-size sections held in a
// synchronous row memory of 64-bit words.
//
//  channel  dir  handshake          payload
//  s        in   s_tvalid/s_tready  s_tuser = func, s_tdata = release_address
//  m        out  m_tvalid/m_tready  m_tdata = granted_address, status
//  apb      in   psel/penable       region_base at byte address 0
//
// Allocate scans 64-bit rows in order, 1 to ceil(SECTION_COUNT/64) of them,
// then marks the first clear bit; an in-range free reads its row and clears the bit.
// The scan reads one map row a cycle through the single memory port.
// Reset clears row valid flags at once; an unwritten row reads as all free.
// A new word is taken while a result waits in the output register; the
// sequencer holds in its final state only while that register stays full.
// ----------------------------------------------------------------------------
module bitmap_section_allocator_core
  import bsa_pkg::*;
#(
  parameter int SECTION_COUNT = SECTION_COUNT_DEF,
  parameter int SECTION_SHIFT = SECTION_SHIFT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ADDR_W-1:0]     s_tdata,   // [31:0] release_address
  input  logic                  s_tuser,   // [0] func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] granted_address, [33:32] status
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int ROWS      = (SECTION_COUNT + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W     = ROW_W + COL_W;
  localparam int SPAN_W    = IDX_W + SECTION_SHIFT;
  localparam int LAST_COLS = SECTION_COUNT - ROW_BITS * (ROWS - 1);
  localparam logic [ROW_BITS-1:0] LAST_MASK =
    (LAST_COLS == ROW_BITS) ? '1 : ((ROW_BITS'(1) << LAST_COLS) - ROW_BITS'(1));
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [ADDR_W-1:0]   region_base;
  state_t              state, state_next;

  logic [ROW_BITS-1:0] mem [0:ROWS-1];
  logic [ROWS-1:0]     row_valid;
  logic [ROW_BITS-1:0] rd_data;
  logic                rd_valid;

  logic                mem_re;
  logic                mem_we;
  logic [ROW_W-1:0]    mem_addr;
  logic [ROW_BITS-1:0] mem_wdata;

  logic [ROW_W-1:0]    scan_row;
  logic [IDX_W-1:0]    idx;
  logic [ADDR_W-1:0]   offset;
  status_t             status;

  logic                s_accept;
  logic                out_load;
  logic                in_range;
  logic [ROW_BITS-1:0] row_raw;
  logic [ROW_BITS-1:0] row_busy;
  logic                row_hit;
  logic [COL_W-1:0]    hit_col;
  logic [IDX_W-1:0]    free_idx;
  logic [SPAN_W-1:0]   span_wide;
  logic [SPAN_W+ADDR_W-1:0] span_ext;
  logic [ADDR_W-1:0]   grant_addr;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_REGION_BASE) ? region_base : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
    end else if (psel && penable && pwrite && paddr == REG_REGION_BASE) begin
      region_base <= pwdata;
    end
  end

  assign s_accept = s_tvalid && s_tready;
  assign row_raw  = rd_valid ? rd_data : '0;
  assign row_busy = row_raw | ((scan_row == LAST_ROW) ? ~LAST_MASK : '0);
  assign row_hit  = !(&row_busy);
  assign hit_col  = first_zero(row_busy);
  assign in_range = (offset >> SECTION_SHIFT) < ADDR_W'(SECTION_COUNT);
  assign free_idx = IDX_W'(offset >> SECTION_SHIFT);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next = (func_t'(s_tuser) == FUNC_ALLOC) ? ST_ALLOC : ST_FREE_RD;
        end
      end
      ST_ALLOC: begin
        if (row_hit || scan_row == LAST_ROW) begin
          state_next = ST_DONE;
        end
      end
      ST_FREE_RD: state_next = in_range ? ST_FREE_WR : ST_DONE;
      ST_FREE_WR: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = row_raw;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        mem_re   = s_accept && func_t'(s_tuser) == FUNC_ALLOC;
      end
      ST_ALLOC: begin
        if (row_hit) begin
          mem_we    = 1'b1;
          mem_addr  = scan_row;
          mem_wdata = row_raw | (ROW_BITS'(1) << hit_col);
        end else if (scan_row != LAST_ROW) begin
          mem_re   = 1'b1;
          mem_addr = scan_row + ROW_W'(1);
        end
      end
      ST_FREE_RD: begin
        mem_re   = in_range;
        mem_addr = free_idx[IDX_W-1:COL_W];
      end
      ST_FREE_WR: begin
        mem_we    = 1'b1;
        mem_addr  = idx[IDX_W-1:COL_W];
        mem_wdata = row_raw & ~(ROW_BITS'(1) << idx[COL_W-1:0]);
      end
      ST_DONE: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid[mem_addr] <= 1'b1;
      end
      if (mem_re) begin
        rd_valid <= row_valid[mem_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        scan_row <= '0;
        offset   <= s_tdata - region_base;
      end
      ST_ALLOC: begin
        if (row_hit) begin
          idx    <= {scan_row, hit_col};
          status <= STATUS_GRANTED;
        end else if (scan_row == LAST_ROW) begin
          status <= STATUS_NO_FREE;
        end else begin
          scan_row <= scan_row + ROW_W'(1);
        end
      end
      ST_FREE_RD: begin
        idx    <= free_idx;
        status <= in_range ? STATUS_FREED : STATUS_RANGE;
      end
      default: ;
    endcase
  end

  assign span_wide  = {idx, {SECTION_SHIFT{1'b0}}};
  assign span_ext   = (SPAN_W + ADDR_W)'(span_wide);
  assign grant_addr = (status == STATUS_GRANTED) ? region_base + span_ext[ADDR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(M_TDATA_W - ADDR_W - STATUS_W){1'b0}}, status, grant_addr};
    end
  end

endmodule

/* hdl/bsa_checker.sv */
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks for the bitmap section allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker
  import bsa_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word present after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while one is in flight");

  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[33:32] != STATUS_GRANTED) |-> (m_tdata[31:0] == 32'd0))
    else $error("nonzero address on a result that granted nothing");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed");

endmodule

bind bitmap_section_allocator_core bsa_checker u_bsa_checker (.*);

/* bench/bitmap_section_allocator_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_section_allocator_core_test
// Drives allocate and free requests through the stream input, moves the
// region base over the register port between phases, and checks every result
// word against a local bitmap predictor. Directed rows first, then filling,
// emptying and mixed random traffic with random stalls on both sides.
// ----------------------------------------------------------------------------
module bitmap_section_allocator_core_test;
  import bsa_pkg::*;

  localparam int SECTIONS     = SECTION_COUNT_DEF;
  localparam int SHIFT        = SECTION_SHIFT_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 8;
  localparam int SCRIPT_LEN   = 21;
  localparam int PHASES       = 5;
  localparam int MIXED_ITEMS  = 60;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd4;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted;
    status_t           status;
  } grant_t;

  typedef struct packed {
    row_kind_t             kind;
    func_t                 func;
    logic [CFG_ADDR_W-1:0] reg_addr;
    logic [31:0]           value;
    logic                  typed;
    logic [ADDR_W-1:0]     granted;
    status_t               status;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [ADDR_W-1:0]     s_tdata;   // [31:0] release_address
  logic                  s_tuser;   // [0] func
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;   // [31:0] granted_address, [33:32] status
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  logic [SECTIONS-1:0] map_bits;
  logic [ADDR_W-1:0]   base_addr;
  grant_t              pending_grants[$];
  row_t                script[0:SCRIPT_LEN-1];
  int                  error_count;
  int                  cycle_count;
  int                  status_seen[4];
  int                  base_writes;
  int                  words_sent;
  int                  rx_hold;
  bit                  rx_stalls_on;
  bit                  tx_gaps_on;

  bitmap_section_allocator_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 8);
    else return $urandom_range(20, 40);
  endfunction

  task automatic section_request(input func_t f, input logic [ADDR_W-1:0] addr,
                                 output grant_t g);
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] idx;
    int                slot;
    g.granted = '0;
    if (f == FUNC_ALLOC) begin
      slot = -1;
      for (int i = SECTIONS - 1; i >= 0; i--) begin
        if (!map_bits[i]) slot = i;
      end
      if (slot < 0) begin
        g.status = STATUS_NO_FREE;
      end else begin
        map_bits[slot] = 1'b1;
        g.granted = base_addr + (ADDR_W'(slot) << SHIFT);
        g.status = STATUS_GRANTED;
      end
    end else begin
      offset = addr - base_addr;
      idx = offset >> SHIFT;
      if (idx < SECTIONS) begin
        map_bits[idx] = 1'b0;
        g.status = STATUS_FREED;
      end else begin
        g.status = STATUS_RANGE;
      end
    end
  endtask

  task automatic send_request(input func_t f, input logic [ADDR_W-1:0] addr,
                              input logic typed, input grant_t typed_grant);
    grant_t g;
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= addr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    section_request(f, addr, g);
    if (typed) g = typed_grant;
    pending_grants.push_back(g);
    words_sent++;
    if (tx_gaps_on && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_REGION_BASE) begin
      base_addr = data;
      base_writes++;
    end
    @(posedge clk);
    if (addr == REG_REGION_BASE && prdata !== data) begin
      $error("region_base: expected %h, got %h", data, prdata);
      error_count++;
    end
  endtask

  task automatic free_somewhere_owned();
    int idx;
    idx = $urandom_range(0, SECTIONS - 1);
    if (map_bits != '0) begin
      while (!map_bits[idx]) idx = $urandom_range(0, SECTIONS - 1);
    end
    send_request(FUNC_FREE, base_addr + (ADDR_W'(idx) << SHIFT) +
                 ADDR_W'($urandom_range(0, (1 << SHIFT) - 1)), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst && m_tvalid && m_tready) begin
      status_seen[m_tdata[33:32]]++;
      if (pending_grants.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        error_count++;
      end else begin
        want = pending_grants.pop_front();
        if (m_tdata[31:0] !== want.granted) begin
          $error("granted_address: expected %h, got %h", want.granted, m_tdata[31:0]);
          error_count++;
        end
        if (m_tdata[33:32] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[33:32]);
          error_count++;
        end
        if (m_tdata[M_TDATA_W-1:34] !== '0) begin
          $error("pad: expected 0, got %h", m_tdata[M_TDATA_W-1:34]);
          error_count++;
        end
      end
    end
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (rx_stalls_on && $urandom_range(0, 3) == 0) rx_hold <= gap_len();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] phase_base;
    int                burst;
    int                r;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= FUNC_ALLOC;
    m_tready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    map_bits = '0;
    base_addr = '0;
    error_count = 0;
    cycle_count = 0;
    base_writes = 0;
    words_sent = 0;
    rx_hold = 0;
    rx_stalls_on = 1'b1;
    tx_gaps_on = 1'b1;
    status_seen = '{0, 0, 0, 0};

    script = '{
      '{ROW_REQ, FUNC_ALLOC, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_GRANTED},
      '{ROW_REQ, FUNC_ALLOC, 3'd0, 32'h0000_0000, 1'b1, 32'h0010_0000, STATUS_GRANTED},
      '{ROW_REQ, FUNC_FREE,  3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_FREED},
      '{ROW_REQ, FUNC_ALLOC, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_GRANTED},
      '{ROW_REQ, FUNC_FREE,  3'd0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_RANGE},
      '{ROW_REQ, FUNC_FREE,  3'd0, 32'h03FF_FFFF, 1'b1, 32'h0000_0000, STATUS_FREED},
      '{ROW_REQ, FUNC_FREE,  3'd0, 32'h0400_0000, 1'b1, 32'h0000_0000, STATUS_RANGE},
      '{ROW_REQ, FUNC_FREE,  3'd0, 32'h001A_BCDE, 1'b0, 32'h0000_0000, STATUS_FREED},
      '{ROW_REQ, FUNC_ALLOC, 3'd0, 32'h0000_0000, 1'b1, 32'h0010_0000, STATUS_GRANTED},
      '{ROW_CFG, FUNC_ALLOC, REG_REGION_BASE, 32'hFFFF_FFFF, 1'b0, 32'h0, STATUS_GRANTED},
      '{ROW_REQ, FUNC_ALLOC, 3'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_GRANTED},
      '{ROW_REQ, FUNC_FREE,  3'd0, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000, STATUS_RANGE},
      '{ROW_REQ, FUNC_FREE,  3'd0, 32'h000F_FFFF, 1'b1, 32'h0000_0000, STATUS_FREED},
      '{ROW_CFG, FUNC_ALLOC, REG_UNUSED, 32'h1234_5678, 1'b0, 32'h0, STATUS_GRANTED},
      '{ROW_REQ, FUNC_ALLOC, 3'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_GRANTED},
      '{ROW_CFG, FUNC_ALLOC, REG_REGION_BASE, 32'h8000_0000, 1'b0, 32'h0, STATUS_GRANTED},
      '{ROW_REQ, FUNC_FREE,  3'd0, 32'h8000_0000, 1'b1, 32'h0000_0000, STATUS_FREED},
      '{ROW_REQ, FUNC_ALLOC, 3'd0, 32'h0000_0000, 1'b1, 32'h8000_0000, STATUS_GRANTED},
      '{ROW_REQ, FUNC_FREE,  3'd0, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, STATUS_RANGE},
      '{ROW_CFG, FUNC_ALLOC, REG_REGION_BASE, 32'h0000_0000, 1'b0, 32'h0, STATUS_GRANTED},
      '{ROW_REQ, FUNC_ALLOC, 3'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_GRANTED}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].kind == ROW_CFG) begin
        write_reg(script[i].reg_addr, script[i].value);
      end else begin
        send_request(script[i].func, script[i].value, script[i].typed,
                     {script[i].granted, script[i].status});
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_base = 32'h0000_0000;
        1: phase_base = 32'hFFFF_FFFF;
        2: phase_base = 32'hFFF0_0000;
        3: phase_base = $urandom;
        default: phase_base = $urandom & 32'hFFF0_0000;
      endcase
      write_reg(REG_REGION_BASE, phase_base);
      tx_gaps_on = (p != 1);
      rx_stalls_on = (p != 1);

      // fill past the top so the full case shows up
      if (p % 2 == 0) begin
        burst = SECTIONS + 2 - $countones(map_bits);
        repeat (burst) send_request(FUNC_ALLOC, $urandom, 1'b0, '0);
      end
      // release every owned section
      if (p == 3) begin
        while (map_bits != '0) free_somewhere_owned();
      end

      for (int n = 0; n < MIXED_ITEMS; n++) begin
        if (p == 2 && n == MIXED_ITEMS / 2) drain();
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send_request(FUNC_ALLOC, $urandom, 1'b0, '0);
        end else if (r < 80) begin
          free_somewhere_owned();
        end else if (r < 90) begin
          send_request(FUNC_FREE, $urandom, 1'b0, '0);
        end else if (r < 95) begin
          send_request(FUNC_FREE, base_addr + (ADDR_W'(SECTIONS) << SHIFT) +
                       ADDR_W'($urandom_range(0, 3)) - 32'd2, 1'b0, '0);
        end else begin
          send_request(FUNC_FREE, base_addr - ADDR_W'($urandom_range(1, 4)), 1'b0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("sent %0d requests over %0d region bases", words_sent, base_writes + 1);
    $display("seen: %0d granted, %0d full, %0d freed, %0d out of range",
             status_seen[STATUS_GRANTED], status_seen[STATUS_NO_FREE],
             status_seen[STATUS_FREED], status_seen[STATUS_RANGE]);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
